### hw/rtl/cdly_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus delay package
// Shared constants, register codes and the sine table generator.
// ----------------------------------------------------------------------------
package cdly_pkg;

   localparam int BUF_DEPTH_DEF       = 65536;
   localparam int MAX_VOICES_DEF      = 8;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int SAMPLE_W = 24;
   localparam int LFO_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP = 3'd0,
      CSR_BASE_DELAY = 3'd1,
      CSR_DEPTH      = 3'd2,
      CSR_VOICES     = 3'd3,
      CSR_MIX        = 3'd4,
      CSR_BUF_LEN    = 3'd5
   } csr_index_type;

   // 32767*sin(pi/2 * r/Q), Q = 2^(bits-2), Taylor series in Q30
   function automatic logic signed [LFO_W-1:0] quarter_sine(longint r, int bits);
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint res;
      begin
         x    = (HALF_PI_Q30 * r) >>> (bits - 2);
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >>> 30;
            case (n)
               1: term = term / 6;
               2: term = term / 20;
               3: term = term / 42;
               4: term = term / 72;
               5: term = term / 110;
               default: term = term / 156;
            endcase
            if (n % 2 == 1) sum = sum - term;
            else            sum = sum + term;
         end
         if (sum < 0) sum = 0;
         res = (sum * 32767 + 64'sd536870912) >>> 30;
         return LFO_W'(res);
      end
   endfunction

   function automatic logic signed [LFO_W-1:0] sine_value(int k, int bits);
      int quad;
      int r;
      int q;
      logic signed [LFO_W-1:0] v;
      begin
         q    = 1 << (bits - 2);
         quad = k >> (bits - 2);
         r    = k & (q - 1);
         if (quad % 2 == 1) v = quarter_sine(longint'(q - r), bits);
         else               v = quarter_sine(longint'(r), bits);
         if ((quad / 2) % 2 == 1) v = -v;
         return v;
      end
   endfunction

endpackage

### hw/rtl/multi_voice_chorus_delay_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-voice chorus delay unit
// Stereo chorus on a modulated circular delay line, up to MAX_VOICES voices.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the delay line RAM to zero, one entry per cycle;
// req_ready stays low during that sweep while configuration writes are still
// taken. One stereo pair is processed at a time: it is accepted and stored,
// then each active voice takes an LFO table read, depth multiply, delay
// clamp, tap address, two reads of the single-port delay RAM, interpolate
// and accumulate; a serial divide by the voice count and the dry/wet mix
// follow. The single RAM port and the serial divider limit the pair rate. A
// finished pair waits in the output register and the next pair is accepted
// meanwhile.
module multi_voice_chorus_delay_unit
   import cdly_pkg::*;
#(
   parameter int BUF_DEPTH       = BUF_DEPTH_DEF,
   parameter int MAX_VOICES      = MAX_VOICES_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out
);

   localparam int ADDR_W  = $clog2(BUF_DEPTH);
   localparam int LEN_W   = $clog2(BUF_DEPTH + 1);
   localparam int CMP_W   = (LEN_W > 17) ? LEN_W : 17;
   localparam int VC_W    = $clog2(MAX_VOICES + 1);
   localparam int VI_W    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int SINE_N  = 1 << SINE_TABLE_BITS;
   localparam int PROD_W  = 25 + LFO_W;
   localparam int D_W     = (LEN_W + 10 > 28) ? LEN_W + 10 : 28;
   localparam int VAL_W   = 34;
   localparam int ACC_W   = VAL_W + $clog2(MAX_VOICES + 1);
   localparam int MIX_W   = 54;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE, ST_LFO, ST_MUL, ST_DLY, ST_IDX,
      ST_RD0, ST_RD1, ST_MAC, ST_DIV, ST_DIV_WAIT, ST_MIX1, ST_MIX2
   } state_type;

   // configuration registers
   logic [31:0] phase_step_ff;
   logic [23:0] base_ff;
   logic [23:0] depth_ff;
   logic [3:0]  voices_ff;
   logic [16:0] mix_level_ff;
   logic [16:0] buf_len_ff;

   state_type                   state_ff;
   logic [ADDR_W-1:0]           clr_ff;
   logic [ADDR_W-1:0]           widx_ff;
   logic [LEN_W-1:0]            len_ff;
   logic [VC_W-1:0]             nv_ff;
   logic [16:0]                 mix_ff;
   logic [VI_W-1:0]             vidx_ff;
   logic signed [SAMPLE_W-1:0]  dl_ff, dr_ff;
   logic signed [LFO_W-1:0]     lfo_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [D_W-1:0]       d_ff;
   logic [ADDR_W-1:0]           i0_ff, i1_ff;
   logic signed [SAMPLE_W-1:0]  tl0_ff, tr0_ff;
   logic signed [ACC_W-1:0]     accl_ff, accr_ff;
   logic signed [VAL_W-1:0]     wetl_ff, wetr_ff;
   logic signed [MIX_W-1:0]     pdl_ff, pdr_ff, pwl_ff, pwr_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  outl_ff, outr_ff;
   logic [31:0]                 phase_ff [MAX_VOICES];

   logic signed [LFO_W-1:0]     sine_rom [SINE_N];

   // clamped controls for the pair being accepted
   logic [LEN_W-1:0]  len_c;
   logic [VC_W-1:0]   nv_c;
   logic [16:0]       mix_c;

   always_comb begin
      if (CMP_W'(buf_len_ff) < CMP_W'(4))              len_c = LEN_W'(4);
      else if (CMP_W'(buf_len_ff) > CMP_W'(BUF_DEPTH)) len_c = LEN_W'(BUF_DEPTH);
      else                                             len_c = LEN_W'(buf_len_ff);
      if (voices_ff == '0)                         nv_c = VC_W'(1);
      else if (5'(voices_ff) > 5'(MAX_VOICES))     nv_c = VC_W'(MAX_VOICES);
      else                                         nv_c = VC_W'(voices_ff);
      mix_c = (mix_level_ff > 17'd65536) ? 17'd65536 : mix_level_ff;
   end

   // sine table, built at elaboration
   for (genvar g = 0; g < SINE_N; g++) begin : g_sine
      assign sine_rom[g] = sine_value(g, SINE_TABLE_BITS);
   end

   // per-voice phase accumulators, staggered evenly at reset
   for (genvar g = 0; g < MAX_VOICES; g++) begin : g_phase
      localparam logic [31:0] PH_RST = 32'((64'(g) << 32) / MAX_VOICES);
      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[g] <= PH_RST;
         end else if (state_ff == ST_LFO && vidx_ff == VI_W'(g)) begin
            phase_ff[g] <= phase_ff[g] + phase_step_ff;
         end
      end
   end

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= 32'd89478;
         base_ff       <= 24'd245760;
         depth_ff      <= 24'd0;
         voices_ff     <= 4'd1;
         mix_level_ff  <= 17'd32768;
         buf_len_ff    <= 17'd48000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_BASE_DELAY: base_ff       <= csr_wdata[23:0];
            CSR_DEPTH:      depth_ff      <= csr_wdata[23:0];
            CSR_VOICES:     voices_ff     <= csr_wdata[3:0];
            CSR_MIX:        mix_level_ff  <= csr_wdata[16:0];
            CSR_BUF_LEN:    buf_len_ff    <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // delay line RAM
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_addr;
   logic [2*SAMPLE_W-1:0]     mem_wdata;
   logic [2*SAMPLE_W-1:0]     mem_rdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = {dl_ff, dr_ff};
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            mem_addr = widx_ff;
         end
         ST_RD1:  mem_addr = i1_ff;
         default: mem_addr = i0_ff;
      endcase
   end

   cdly_line_mem #(
      .DEPTH  (BUF_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (2 * SAMPLE_W)
   ) u_line (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // wet sum divided by the active voice count
   logic                    div_done;
   logic signed [ACC_W-1:0] quo_l, quo_r;

   cdly_div #(
      .NUM_W (ACC_W),
      .DEN_W (VC_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIV),
      .num_l (accl_ff),
      .num_r (accr_ff),
      .den   (nv_ff),
      .done  (div_done),
      .quo_l (quo_l),
      .quo_r (quo_r)
   );

   // delay: base + floor(depth * lfo / 2^15), clamped to [1, L-1) samples (L-1 and above become L-2)
   logic signed [D_W-1:0] d_raw, d_hi;
   always_comb begin
      d_raw = signed'(D_W'(base_ff)) + D_W'(prod_ff >>> 15);
      d_hi  = signed'(D_W'({len_ff - LEN_W'(1), 8'd0}));
   end

   // tap addresses, wrapped into the length in use
   logic [LEN_W:0]    t_diff;
   logic [LEN_W:0]    t_wrap;
   logic [ADDR_W-1:0] i0_c;
   always_comb begin
      t_diff = (LEN_W+1)'(widx_ff) - (LEN_W+1)'(d_ff[8 +: ADDR_W]);
      t_wrap = t_diff[LEN_W] ? t_diff + (LEN_W+1)'(len_ff) : t_diff;
      i0_c   = t_wrap[ADDR_W-1:0];
   end

   // interpolation of both channels
   logic signed [SAMPLE_W-1:0] tl1, tr1;
   logic signed [9:0]          w0, w1;
   logic signed [VAL_W-1:0]    vl, vr;
   always_comb begin
      tl1 = mem_rdata[2*SAMPLE_W-1:SAMPLE_W];
      tr1 = mem_rdata[SAMPLE_W-1:0];
      w1  = signed'({2'b00, d_ff[7:0]});
      w0  = 10'sd256 - w1;
      vl  = VAL_W'(tl0_ff * w0) + VAL_W'(tl1 * w1);
      vr  = VAL_W'(tr0_ff * w0) + VAL_W'(tr1 * w1);
   end

   // final mix: floor(sum / 2^24), saturated
   logic signed [MIX_W-1:0] suml, sumr, shl, shr;
   logic signed [SAMPLE_W-1:0] satl, satr;
   always_comb begin
      suml = (pdl_ff <<< 8) + pwl_ff;
      sumr = (pdr_ff <<< 8) + pwr_ff;
      shl  = suml >>> 24;
      shr  = sumr >>> 24;
      if (shl > MIX_W'(8388607))       satl = 24'sh7FFFFF;
      else if (shl < -MIX_W'(8388608)) satl = -24'sh800000;
      else                             satl = shl[SAMPLE_W-1:0];
      if (shr > MIX_W'(8388607))       satr = 24'sh7FFFFF;
      else if (shr < -MIX_W'(8388608)) satr = -24'sh800000;
      else                             satr = shr[SAMPLE_W-1:0];
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = outl_ff;
   assign rsp_right_out = outr_ff;

   // sequencer: one pair at a time, one voice at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         widx_ff      <= '0;
         vidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the mix stage reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_MIX2) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(BUF_DEPTH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  dl_ff  <= req_left_in;
                  dr_ff  <= req_right_in;
                  len_ff <= len_c;
                  nv_ff  <= nv_c;
                  mix_ff <= mix_c;
                  // drop a stale write index after the length shrank
                  if (LEN_W'(widx_ff) >= len_c) widx_ff <= '0;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               accl_ff  <= '0;
               accr_ff  <= '0;
               vidx_ff  <= '0;
               state_ff <= ST_LFO;
            end
            ST_LFO: begin
               lfo_ff   <= sine_rom[phase_ff[vidx_ff][31 -: SINE_TABLE_BITS]];
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= signed'({1'b0, depth_ff}) * lfo_ff;
               state_ff <= ST_DLY;
            end
            ST_DLY: begin
               if (d_raw < D_W'(256))   d_ff <= D_W'(256);
               else if (d_raw >= d_hi)  d_ff <= signed'(D_W'({len_ff - LEN_W'(2), 8'd0}));
               else                     d_ff <= d_raw;
               state_ff <= ST_IDX;
            end
            ST_IDX: begin
               i0_ff    <= i0_c;
               i1_ff    <= (i0_c == '0) ? ADDR_W'(len_ff - LEN_W'(1)) : i0_c - 1'b1;
               state_ff <= ST_RD0;
            end
            ST_RD0: state_ff <= ST_RD1;
            ST_RD1: begin
               tl0_ff   <= mem_rdata[2*SAMPLE_W-1:SAMPLE_W];
               tr0_ff   <= mem_rdata[SAMPLE_W-1:0];
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               accl_ff <= accl_ff + ACC_W'(vl);
               accr_ff <= accr_ff + ACC_W'(vr);
               if (VC_W'(vidx_ff) == nv_ff - VC_W'(1)) begin
                  state_ff <= ST_DIV;
               end else begin
                  vidx_ff  <= vidx_ff + 1'b1;
                  state_ff <= ST_LFO;
               end
            end
            ST_DIV: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  wetl_ff  <= quo_l[VAL_W-1:0];
                  wetr_ff  <= quo_r[VAL_W-1:0];
                  state_ff <= ST_MIX1;
               end
            end
            ST_MIX1: begin
               pdl_ff   <= MIX_W'(dl_ff * signed'({1'b0, 17'd65536 - mix_ff}));
               pdr_ff   <= MIX_W'(dr_ff * signed'({1'b0, 17'd65536 - mix_ff}));
               pwl_ff   <= MIX_W'(wetl_ff * signed'({1'b0, mix_ff}));
               pwr_ff   <= MIX_W'(wetr_ff * signed'({1'b0, mix_ff}));
               state_ff <= ST_MIX2;
            end
            ST_MIX2: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  outl_ff      <= satl;
                  outr_ff      <= satr;
                  rsp_valid_ff <= 1'b1;
                  if (LEN_W'(widx_ff) + LEN_W'(1) == len_ff) widx_ff <= '0;
                  else                                       widx_ff <= widx_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_accept_stores: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_WRITE)
      else $error("accepted pair not stored next cycle");

   a_voice_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> VC_W'(vidx_ff) < nv_ff)
      else $error("voice index beyond active count");

   a_taps_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD0 |-> (LEN_W'(i0_ff) < len_ff) && (LEN_W'(i1_ff) < len_ff))
      else $error("tap address outside the line in use");

   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_MIX2)
      else $error("result raised outside the mix stage");

endmodule

### hw/rtl/cdly_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus delay line memory
// Single-port synchronous RAM holding both channels, registered read data.
// ----------------------------------------------------------------------------
module cdly_line_mem
   import cdly_pkg::*;
#(
   parameter int DEPTH  = BUF_DEPTH_DEF,
   parameter int ADDR_W = $clog2(BUF_DEPTH_DEF),
   parameter int DATA_W = 2 * SAMPLE_W
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/cdly_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus delay divider
// Two-lane serial restoring divider, signed numerator, truncates toward zero.
// ----------------------------------------------------------------------------
module cdly_div
   import cdly_pkg::*;
#(
   parameter int NUM_W = 38,
   parameter int DEN_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num_l,
   input  logic signed [NUM_W-1:0] num_r,
   input  logic        [DEN_W-1:0] den,
   output logic                    done,
   output logic signed [NUM_W-1:0] quo_l,
   output logic signed [NUM_W-1:0] quo_r
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] q_ff   [2];
   logic [DEN_W:0]   rem_ff [2];
   logic             neg_ff [2];
   logic [NUM_W-1:0] q_in   [2];
   logic [DEN_W:0]   rem_in [2];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         logic [DEN_W:0] sh;
         sh = {rem_ff[k][DEN_W-1:0], q_ff[k][NUM_W-1]};
         q_in[k] = {q_ff[k][NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            rem_in[k] = sh - {1'b0, den_ff};
            q_in[k][0] = 1'b1;
         end else begin
            rem_in[k] = sh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff    <= den;
         neg_ff[0] <= num_l[NUM_W-1];
         neg_ff[1] <= num_r[NUM_W-1];
         q_ff[0]   <= num_l[NUM_W-1] ? -num_l : num_l;
         q_ff[1]   <= num_r[NUM_W-1] ? -num_r : num_r;
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done  = done_ff;
   assign quo_l = neg_ff[0] ? -signed'(q_ff[0]) : signed'(q_ff[0]);
   assign quo_r = neg_ff[1] ? -signed'(q_ff[1]) : signed'(q_ff[1]);

endmodule

### tb/sv/tb_multi_voice_chorus_delay_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus delay unit testbench
// Streams stereo pairs through the chorus unit under random valid/ready
// idling and long output stalls, predicts every mixed pair with its own
// delay-line and LFO model, and compares the pairs in order.
// ----------------------------------------------------------------------------
module tb_multi_voice_chorus_delay_unit;
   import cdly_pkg::*;

   localparam int LINE_DEPTH  = 65536;
   localparam int VOICE_SLOTS = 8;
   localparam int LUT_BITS    = 10;
   localparam int LUT_SIZE    = 1 << LUT_BITS;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_pair_t;

   // Predicts the mixed pairs and holds the ones still owed by the unit.
   class chorus_scoreboard;
      logic signed [15:0]         sine_lut [LUT_SIZE];
      logic signed [SAMPLE_W-1:0] left_line [LINE_DEPTH];
      logic signed [SAMPLE_W-1:0] right_line [LINE_DEPTH];
      int unsigned                head;
      logic [31:0]                lfo_phase [VOICE_SLOTS];
      logic [31:0]                phase_step;
      logic [23:0]                base_delay;
      logic [23:0]                depth;
      logic [3:0]                 voices;
      logic [16:0]                mix_level;
      logic [16:0]                line_len;
      stereo_pair_t               owed [$];
      int                         errors;

      function new();
         errors = 0;
         for (int k = 0; k < LUT_SIZE; k++) begin
            int quad;
            int r;
            logic signed [15:0] v;
            quad = k / (LUT_SIZE / 4);
            r    = k % (LUT_SIZE / 4);
            v = (quad % 2 == 1) ? quarter_wave(LUT_SIZE / 4 - r) : quarter_wave(r);
            sine_lut[k] = (quad >= 2) ? -v : v;
         end
         for (int i = 0; i < LINE_DEPTH; i++) begin
            left_line[i]  = '0;
            right_line[i] = '0;
         end
         head = 0;
         for (int i = 0; i < VOICE_SLOTS; i++) lfo_phase[i] = 32'(i) << 29;
         phase_step = 32'd89478;
         base_delay = 24'd245760;
         depth      = 24'd0;
         voices     = 4'd1;
         mix_level  = 17'd32768;
         line_len   = 17'd48000;
      endfunction

      // Taylor series to x^13 in Q30, truncating each step
      function logic signed [15:0] quarter_wave(int r);
         longint x;
         longint x2;
         longint term;
         longint sum;
         longint div [6];
         div = '{6, 20, 42, 72, 110, 156};
         x    = (64'sd1686629713 * longint'(r)) / (LUT_SIZE / 4);
         x2   = (x * x) / 64'sd1073741824;
         term = x;
         sum  = x;
         for (int n = 0; n < 6; n++) begin
            term = (term * x2) / 64'sd1073741824;
            term = term / div[n];
            if (n % 2 == 0) sum = sum - term;
            else            sum = sum + term;
         end
         if (sum < 0) sum = 0;
         return 16'((sum * 32767 + 64'sd536870912) / 64'sd1073741824);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_PHASE_STEP: phase_step = data;
            CSR_BASE_DELAY: base_delay = data[23:0];
            CSR_DEPTH:      depth      = data[23:0];
            CSR_VOICES:     voices     = data[3:0];
            CSR_MIX:        mix_level  = data[16:0];
            CSR_BUF_LEN:    line_len   = data[16:0];
            default: ;
         endcase
      endfunction

      function longint mix_channel(longint dry, longint wet, longint mix);
         longint acc;
         acc = (dry * (65536 - mix) * 256 + wet * mix) >>> 24;
         if (acc > 8388607)  acc = 8388607;
         if (acc < -8388608) acc = -8388608;
         return acc;
      endfunction

      // Store the accepted pair, run every active voice, queue the mixed pair
      function void note_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
         int unsigned  len;
         int unsigned  nv;
         longint       mix;
         longint       wet_l;
         longint       wet_r;
         stereo_pair_t res;
         len = line_len;
         if (len < 4) len = 4;
         if (len > LINE_DEPTH) len = LINE_DEPTH;
         nv = voices;
         if (nv < 1) nv = 1;
         if (nv > VOICE_SLOTS) nv = VOICE_SLOTS;
         mix = (mix_level > 65536) ? 65536 : mix_level;
         if (head >= len) head = 0;
         left_line[head]  = l;
         right_line[head] = r;
         wet_l = 0;
         wet_r = 0;
         for (int v = 0; v < nv; v++) begin
            longint      lfo;
            longint      dly;
            int unsigned ip;
            int unsigned frac;
            int unsigned i0;
            int unsigned i1;
            lfo = sine_lut[lfo_phase[v][31:32-LUT_BITS]];
            lfo_phase[v] = lfo_phase[v] + phase_step;
            dly = longint'(base_delay) + ((longint'(depth) * lfo) >>> 15);
            if (dly < 256) dly = 256;
            if (dly >= longint'(len - 1) * 256) dly = longint'(len - 2) * 256;
            ip   = int'(dly >> 8);
            frac = int'(dly & 255);
            i0 = (head + len - ip) % len;
            i1 = (i0 + len - 1) % len;
            wet_l += longint'(left_line[i0]) * (256 - frac) + longint'(left_line[i1]) * frac;
            wet_r += longint'(right_line[i0]) * (256 - frac)
                     + longint'(right_line[i1]) * frac;
         end
         wet_l = wet_l / longint'(nv);
         wet_r = wet_r / longint'(nv);
         res.left  = SAMPLE_W'(mix_channel(l, wet_l, mix));
         res.right = SAMPLE_W'(mix_channel(r, wet_r, mix));
         owed.push_back(res);
         head = (head + 1) % len;
      endfunction

      function void check_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
         stereo_pair_t exp_pair;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pair %0d %0d", l, r);
            return;
         end
         exp_pair = owed.pop_front();
         if (l !== exp_pair.left || r !== exp_pair.right) begin
            errors++;
            if (errors <= 10)
               $display("pair mismatch: expected %0d %0d, got %0d %0d",
                        exp_pair.left, exp_pair.right, l, r);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_left_in;
   logic signed [SAMPLE_W-1:0] req_right_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;

   chorus_scoreboard sb;
   bit               calm;        // no idling on either side while set
   int               hold_off;    // receiver stall cycles still to serve
   int               cycles;

   multi_voice_chorus_delay_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: covers the RAM clearing sweep and every stall many times over
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Check every pair transfer on the result channel
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_pair(rsp_left_out, rsp_right_out);
   end

   // Receiver: serve a requested stall first, else idle about a third of the time
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
         end
      end
   end

   // Called just after a falling edge; returns just after a falling edge
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
      while (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pair(l, r);
      @(negedge clock);
   endtask

   // Returns just after a falling edge with csr_valid still high; the caller
   // drops it once the last write of a group is done
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Hold until every owed pair has come back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_all(input logic [31:0] step, input logic [31:0] base,
                            input logic [31:0] dep, input logic [31:0] nv,
                            input logic [31:0] mix, input logic [31:0] len);
      write_csr(CSR_PHASE_STEP, step);
      write_csr(CSR_BASE_DELAY, base);
      write_csr(CSR_DEPTH, dep);
      write_csr(CSR_VOICES, nv);
      write_csr(CSR_MIX, mix);
      write_csr(CSR_BUF_LEN, len);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 24'sh7FFFFF;
         1:       return -24'sh800000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample());
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] corners [8];
      sb = new();
      corners = '{24'sh7FFFFF, -24'sh800000, 24'sh000000, -24'sh000001,
                  24'sh000001, 24'sh555555, -24'sh555556, 24'sh400000};
      calm = 1'b0;
      hold_off = 0;
      cycles = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_left_in = '0;
      req_right_in = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: sample extremes against each other
      for (int i = 0; i < 8; i++) send_pair(corners[i], corners[7 - i]);
      drain();

      // Lower-end settings; shrinking the line leaves a stale write pointer,
      // and out-of-range length and voice count clamp
      write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0);
      write_csr(CSR_SPARE_A, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      for (int i = 0; i < 8; i++) send_pair(corners[i], corners[i]);
      drain();

      // Upper-end settings: full swing, mix above one, length above the RAM
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hF, 32'h1_FFFF, 32'h1_FFFF);
      write_csr(CSR_SPARE_B, 32'd3);
      csr_valid <= 1'b0;
      for (int i = 0; i < 8; i++) send_pair(corners[7 - i], corners[i]);
      drain();

      // Random settings; short lines so the taps land on live data
      for (int ph = 0; ph < 6; ph++) begin
         write_all($urandom,
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 24 * 256),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 16 * 256),
                   $urandom,
                   ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 65536),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 48));
         csr_valid <= 1'b0;
         calm = (ph == 1);
         if (ph == 3) hold_off = 3000;   // fill the unit up and stall its input
         send_random(62);
         drain();
      end
      calm = 1'b0;

      if (sb.owed.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/cdly_pkg.sv
hw/rtl/cdly_line_mem.sv
hw/rtl/cdly_div.sv
hw/rtl/multi_voice_chorus_delay_unit.sv
tb/sv/tb_multi_voice_chorus_delay_unit.sv
